// File: sv/bcc_pkg.sv
// ---------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the button click classifier
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int unsigned HOLD_W = 16;
    localparam int unsigned GAP_W  = 8;
    localparam int unsigned CFG_DW = 16;
    localparam int unsigned CFG_AW = 2;

    localparam logic [HOLD_W-1:0] HOLD_SAT = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_SHORT_MIN  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SHORT_MAX  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LONG       = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_DOUBLE_GAP = 2'd3;

    localparam logic [HOLD_W-1:0] RST_SHORT_MIN  = 16'd1;
    localparam logic [HOLD_W-1:0] RST_SHORT_MAX  = 16'd40;
    localparam logic [HOLD_W-1:0] RST_LONG       = 16'd120;
    localparam logic [GAP_W-1:0]  RST_DOUBLE_GAP = 8'd50;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_bcc_event;

    typedef struct packed {
        logic [HOLD_W-1:0] short_min_ticks;
        logic [HOLD_W-1:0] short_max_ticks;
        logic [HOLD_W-1:0] long_ticks;
        logic [GAP_W-1:0]  double_gap_ticks;
    } t_bcc_cfg;

    typedef struct packed {
        logic       click_pending;
        t_bcc_event click_event;
    } t_bcc_res;

endpackage

`default_nettype wire

// File: sv/button_click_classifier_top.sv
// ---------------------------------------------------------------------------
// button_click_classifier_top
// sorts sampled button levels into single, double and long press events
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one button sample per word (tdata bit 0, 1 = pressed).
//   m_axis returns one word per sample: the click event code and whether a
//   first click is still waiting for a second one.
//   the cfg port writes the short window, long threshold and double gap;
//   write it only while no sample is in flight.
// path: a sample accepted on s_axis is held in the input register and
//   classified into the result register once that register is free or
//   drains, after which its word is valid on m_axis.
// throughput: one sample per cycle while m_axis tready stays high; the
//   hold and gap counters update as each sample is classified.
// reset: counters and flags clear, registers return to 1 / 40 / 120 / 50,
//   both pipeline stages empty.
// stall: when m_axis tready is low the result word holds, the input
//   register keeps one more sample, and s_axis tready then drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bcc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire [bcc_pkg::CFG_DW-1:0]     i_cfg_data,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire [7:0]                     i_s_axis_tdata,  // [0] button_down
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata   // [1:0] click_event, [2] click_pending
);
    import bcc_pkg::*;

    t_bcc_cfg r_cfg;
    logic     r_in_valid;
    logic     r_in_down;
    logic     r_out_valid;
    t_bcc_res r_out;
    t_bcc_res core_res;
    logic     advance;
    logic     in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min_ticks  <= RST_SHORT_MIN;
            r_cfg.short_max_ticks  <= RST_SHORT_MAX;
            r_cfg.long_ticks       <= RST_LONG;
            r_cfg.double_gap_ticks <= RST_DOUBLE_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SHORT_MIN:  r_cfg.short_min_ticks  <= i_cfg_data;
                CFG_SHORT_MAX:  r_cfg.short_max_ticks  <= i_cfg_data;
                CFG_LONG:       r_cfg.long_ticks       <= i_cfg_data;
                CFG_DOUBLE_GAP: r_cfg.double_gap_ticks <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // the input word moves on whenever the result register is free or drains
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_down <= i_s_axis_tdata[0];
        end
    end

    bcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_down  (r_in_down),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.click_pending, r_out.click_event};

endmodule

`default_nettype wire

// File: sv/bcc_core.sv
// ---------------------------------------------------------------------------
// bcc_core
// hold and gap counters with the per-sample classification logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_down,
    input  bcc_pkg::t_bcc_cfg i_cfg,
    output bcc_pkg::t_bcc_res o_res
);
    import bcc_pkg::*;

    logic [HOLD_W-1:0] r_hold, n_hold;
    logic              r_long_done, n_long_done;
    logic              r_first_wait, n_first_wait;
    logic [GAP_W-1:0]  r_gap, n_gap;

    logic [HOLD_W-1:0] hold_inc;
    logic              short_ok;
    logic              wait_mid;
    logic [GAP_W-1:0]  gap_mid;
    t_bcc_event        ev;

    assign hold_inc = (r_hold < HOLD_SAT) ? r_hold + 1'b1 : r_hold;
    assign short_ok = !r_long_done && (r_hold >= i_cfg.short_min_ticks)
                      && (r_hold <= i_cfg.short_max_ticks);

    always_comb begin
        n_hold       = r_hold;
        n_long_done  = r_long_done;
        n_first_wait = r_first_wait;
        n_gap        = r_gap;
        wait_mid     = r_first_wait;
        gap_mid      = r_gap;
        ev           = EV_NONE;
        if (i_down) begin
            n_hold = hold_inc;
            if (!r_long_done && hold_inc >= i_cfg.long_ticks) begin
                n_long_done  = 1'b1;
                n_first_wait = 1'b0;
                n_gap        = '0;
                ev           = EV_LONG;
            end
        end else begin
            // released: on the release edge classify the hold that just ended, then run the gap counter
            if (r_hold != '0) begin
                if (short_ok) begin
                    if (r_first_wait) begin
                        ev       = EV_DOUBLE;
                        wait_mid = 1'b0;
                    end else begin
                        wait_mid = 1'b1;
                    end
                    gap_mid = '0;
                end
                n_hold      = '0;
                n_long_done = 1'b0;
            end
            n_first_wait = wait_mid;
            n_gap        = gap_mid;
            if (wait_mid) begin
                if (gap_mid < i_cfg.double_gap_ticks) begin
                    n_gap = gap_mid + 1'b1;
                end else begin
                    ev           = EV_SINGLE;
                    n_first_wait = 1'b0;
                    n_gap        = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= '0;
            r_long_done  <= 1'b0;
            r_first_wait <= 1'b0;
            r_gap        <= '0;
        end else if (i_en) begin
            r_hold       <= n_hold;
            r_long_done  <= n_long_done;
            r_first_wait <= n_first_wait;
            r_gap        <= n_gap;
        end
    end

    assign o_res.click_event   = ev;
    assign o_res.click_pending = n_first_wait;

`ifndef SYNTH
    a_long_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && ev == EV_LONG |=> r_long_done)
        else $error("long press did not mark the hold as done");
    a_double_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (ev == EV_DOUBLE || ev == EV_SINGLE) |-> !n_first_wait)
        else $error("click event left a click pending");
    a_long_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_done |-> r_hold != '0)
        else $error("long press flag set without a hold");
    a_gap_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_first_wait |-> r_gap == '0)
        else $error("gap counter running with no click pending");
`endif

endmodule

`default_nettype wire

// File: test/button_click_checker.sv
// ---------------------------------------------------------------------------
// button_click_checker
// watches the sample and event streams of the click classifier, keeps its
// own copy of the hold and gap counters, and checks every event word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [bcc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire [bcc_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire                       i_s_tvalid,
    input  wire                       i_s_tready,
    input  wire [7:0]                 i_s_tdata,   // [0] button_down
    input  wire                       i_m_tvalid,
    input  wire                       i_m_tready,
    input  wire [7:0]                 i_m_tdata,   // [1:0] click_event, [2] click_pending
    output int                        o_fail_count,
    output int                        o_outstanding
);

    import bcc_pkg::*;

    t_bcc_cfg          thresholds;
    logic [HOLD_W-1:0] hold_cnt    = '0;
    logic              long_fired  = 1'b0;
    logic              click_armed = 1'b0;
    logic [GAP_W-1:0]  gap_cnt     = '0;
    t_bcc_res          events_due[$];
    int                fails       = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // advances the button state by one sample and returns the event word
    function automatic t_bcc_res classify_sample(input logic down);
        t_bcc_event ev;
        t_bcc_res   res;
        ev = EV_NONE;
        if (down) begin
            if (hold_cnt != HOLD_SAT)
                hold_cnt = hold_cnt + 1'b1;
            if (!long_fired && hold_cnt >= thresholds.long_ticks) begin
                long_fired  = 1'b1;
                click_armed = 1'b0;
                gap_cnt     = '0;
                ev          = EV_LONG;
            end
        end else begin
            if (hold_cnt != '0) begin
                if (!long_fired && hold_cnt >= thresholds.short_min_ticks &&
                    hold_cnt <= thresholds.short_max_ticks) begin
                    if (click_armed) begin
                        ev          = EV_DOUBLE;
                        click_armed = 1'b0;
                    end else begin
                        click_armed = 1'b1;
                    end
                    gap_cnt = '0;
                end
                hold_cnt   = '0;
                long_fired = 1'b0;
            end
            // the releasing tick already counts toward the gap
            if (click_armed) begin
                if (gap_cnt < thresholds.double_gap_ticks) begin
                    gap_cnt = gap_cnt + 1'b1;
                end else begin
                    ev          = EV_SINGLE;
                    click_armed = 1'b0;
                    gap_cnt     = '0;
                end
            end
        end
        res.click_event   = ev;
        res.click_pending = click_armed;
        return res;
    endfunction

    function automatic void flag_field(input string field, input int want, input int got);
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        fails++;
    endfunction

    always @(posedge i_clk) begin : track
        t_bcc_res got;
        t_bcc_res want;
        if (!i_rst_n) begin
            thresholds.short_min_ticks  = RST_SHORT_MIN;
            thresholds.short_max_ticks  = RST_SHORT_MAX;
            thresholds.long_ticks       = RST_LONG;
            thresholds.double_gap_ticks = RST_DOUBLE_GAP;
            hold_cnt    = '0;
            long_fired  = 1'b0;
            click_armed = 1'b0;
            gap_cnt     = '0;
            events_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SHORT_MIN:  thresholds.short_min_ticks  = i_cfg_data;
                    CFG_SHORT_MAX:  thresholds.short_max_ticks  = i_cfg_data;
                    CFG_LONG:       thresholds.long_ticks       = i_cfg_data;
                    CFG_DOUBLE_GAP: thresholds.double_gap_ticks = i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            // a word leaving now belongs to an older sample, so pop first
            if (i_m_tvalid && i_m_tready) begin
                got.click_event   = t_bcc_event'(i_m_tdata[1:0]);
                got.click_pending = i_m_tdata[2];
                if (events_due.size() == 0) begin
                    $error("event word with nothing expected: event %0d, pending %0d",
                           got.click_event, got.click_pending);
                    fails++;
                end else begin
                    want = events_due.pop_front();
                    if (got.click_event !== want.click_event)
                        flag_field("click_event", want.click_event, got.click_event);
                    if (got.click_pending !== want.click_pending)
                        flag_field("click_pending", want.click_pending, got.click_pending);
                end
            end
            if (i_s_tvalid && i_s_tready)
                events_due.push_back(classify_sample(i_s_tdata[0]));
        end
        o_fail_count  <= fails;
        o_outstanding <= events_due.size();
    end

endmodule

// File: test/tb_button_click_classifier_top.sv
// ---------------------------------------------------------------------------
// tb_button_click_classifier_top
// drives button samples through the click classifier under random gaps and
// back-pressure, across several threshold settings, and reports the verdict
// of the checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_click_classifier_top;

    import bcc_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CAP      = 400;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr = '0;
    logic [CFG_DW-1:0]  cfg_data = '0;
    logic               s_valid  = 1'b0;
    logic [7:0]         s_data   = '0;
    wire                s_ready;
    wire                m_valid;
    wire  [7:0]         m_data;
    logic               m_ready  = 1'b0;

    int fail_count;
    int outstanding;
    int cycles     = 0;
    int n_samples  = 0;
    bit s_idle_on  = 1'b1;
    bit m_idle_on  = 1'b1;

    // thresholds currently loaded, used to shape the gestures
    int cur_min  = 1;
    int cur_max  = 40;
    int cur_long = 120;
    int cur_gap  = 50;

    button_click_classifier_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    button_click_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_button_click_classifier_top: errors");
            $finish;
        end
    end

    // event sink with random stalls
    initial begin : event_sink
        int stall;
        forever begin
            stall = m_idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
        end
    end

    task automatic send_sample(input logic down);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, down};
        do @(posedge clk); while (!s_ready);
        n_samples++;
    endtask

    task automatic click(input int hold, input int rel);
        repeat (hold) send_sample(1'b1);
        repeat (rel) send_sample(1'b0);
    endtask

    // wait for every event word, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_thresholds(input int mn, input int mx, input int lg, input int gp);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_SHORT_MIN;
        cfg_data <= 16'(mn);
        @(posedge clk);
        cfg_addr <= CFG_SHORT_MAX;
        cfg_data <= 16'(mx);
        @(posedge clk);
        cfg_addr <= CFG_LONG;
        cfg_data <= 16'(lg);
        @(posedge clk);
        // upper byte is junk, only the low byte lands in the gap register
        cfg_addr <= CFG_DOUBLE_GAP;
        cfg_data <= {8'($urandom), 8'(gp)};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_min  = mn & 16'hFFFF;
        cur_max  = mx & 16'hFFFF;
        cur_long = lg & 16'hFFFF;
        cur_gap  = gp & 8'hFF;
    endtask

    function automatic int pick(input int lo, input int hi);
        if (lo < 1) lo = 1;
        if (hi > HOLD_CAP) hi = HOLD_CAP;
        if (hi < lo) return $urandom_range(1, 24);
        return $urandom_range(lo, hi);
    endfunction

    task automatic random_gesture();
        int hold;
        int rel;
        case ($urandom_range(0, 9))
            0: begin
                // noise burst
                repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(0, 1)));
                return;
            end
            1, 2, 3: hold = pick(cur_min, (cur_max < cur_long) ? cur_max : cur_long - 1);
            4:       hold = pick(1, cur_min - 1);
            5:       hold = pick(cur_max + 1, cur_long - 1);
            6:       hold = pick(cur_long, cur_long + 8);
            default: hold = pick(1, 24);
        endcase
        case ($urandom_range(0, 3))
            0:       rel = pick(1, cur_gap);
            1:       rel = pick(cur_gap, cur_gap + 2);
            2:       rel = pick(1, 3);
            default: rel = pick(cur_gap + 1, cur_gap + 12);
        endcase
        click(hold, rel);
    endtask

    initial begin : stimulus
        int mn, mx, lg, gp;
        int phase_len;
        int start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: arm, double, arm and time out, long press
        click(3, 2);
        click(2, 3);
        click(4, 52);
        click(121, 2);
        settle();

        // tight window: below min, double, single, middle hold, long cancel
        load_thresholds(2, 4, 6, 3);
        click(1, 1);
        click(3, 1);
        click(2, 2);
        click(4, 5);
        click(5, 2);
        click(3, 1);
        click(8, 2);
        settle();

        // zero gap fires single on the releasing tick
        load_thresholds(1, 3, 4, 0);
        click(2, 1);
        click(1, 2);
        settle();

        // min above max never arms
        load_thresholds(5, 3, 10, 2);
        click(4, 3);
        click(5, 2);
        settle();

        // zero long threshold and zero min
        load_thresholds(0, 2, 0, 1);
        click(1, 1);
        click(2, 2);
        settle();

        // widest settings
        load_thresholds(0, 65535, 65535, 255);
        click(3, 2);
        click(4, 3);
        click(2, 258);
        settle();
        load_thresholds(65535, 65535, 1, 0);
        click(1, 2);
        click(3, 1);
        settle();

        start = n_samples;
        while (n_samples - start < RANDOM_ITEMS) begin
            mn = $urandom_range(0, 6);
            mx = $urandom_range(0, 14);
            lg = $urandom_range(0, 30);
            gp = $urandom_range(0, 12);
            case ($urandom_range(0, 7))
                0:       mn = 0;
                1:       mx = 65535;
                2:       lg = 65535;
                3:       gp = 255;
                4:       mn = 65535;
                5:       gp = 0;
                default: ;
            endcase
            load_thresholds(mn, mx, lg, gp);
            s_idle_on = ($urandom_range(0, 3) != 0);
            m_idle_on = ($urandom_range(0, 3) != 0);
            phase_len = n_samples + $urandom_range(60, 200);
            while (n_samples < phase_len)
                random_gesture();
            settle();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("tb_button_click_classifier_top: clean");
        else
            $display("tb_button_click_classifier_top: errors");
        $finish;
    end

endmodule
